// ----- rtl/core/mps_pkg.sv -----
// Package: types, constants and helpers shared by the chain position scorer.
package mps_pkg;

    localparam int unsigned AddrW      = 18;
    localparam int unsigned WordW      = 16;
    localparam int unsigned PieceCodes = 13;
    localparam int unsigned BulkSites  = 63;
    localparam int unsigned Frac       = 14;
    localparam int unsigned MatMax     = 16383;
    localparam int unsigned ScoreShift = 36;

    typedef enum logic [3:0] {
        t_idle_s,
        t_load_s,
        t_mac_s,
        t_col_s,
        t_sqrt_s,
        t_div_s,
        t_dot_s,
        t_score_s,
        t_done_s
    } t_state;

    typedef enum logic [1:0] {
        t_op_none,
        t_op_mac,
        t_op_clear
    } t_mac_op;

    // Material value of a piece code; codes above the range count as empty.
    function automatic logic [9:0] piece_value(input logic [3:0] code);
        logic [9:0] v;
        case (code)
            4'd1, 4'd7:  v = 10'd100;
            4'd2, 4'd8:  v = 10'd320;
            4'd3, 4'd9:  v = 10'd330;
            4'd4, 4'd10: v = 10'd500;
            4'd5, 4'd11: v = 10'd900;
            default:     v = 10'd0;
        endcase
        return v;
    endfunction

    function automatic logic [13:0] add_mat(input logic [13:0] m, input logic [9:0] v);
        logic [14:0] s;
        s = {1'b0, m} + {5'd0, v};
        return (s > 15'(MatMax)) ? 14'(MatMax) : s[13:0];
    endfunction

endpackage

// ----- rtl/core/mps_mac.sv -----
// Shared signed multiply-accumulate unit with registered accumulator.
module mps_mac #(
    parameter int unsigned AccW = 48
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mps_pkg::t_mac_op        i_op,
    input  logic signed [16:0]      i_a,
    input  logic signed [16:0]      i_b,
    output logic signed [AccW-1:0]  o_acc
);
    import mps_pkg::*;

    logic signed [AccW-1:0] r_acc;
    logic signed [33:0]     prod;

    assign prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            case (i_op)
                t_op_mac:   r_acc <= r_acc + AccW'(prod);
                t_op_clear: r_acc <= '0;
                default:    r_acc <= r_acc;
            endcase
        end
    end

    assign o_acc = r_acc;
endmodule

// ----- rtl/core/mps_chain_position_scorer_core.sv -----
// Top level: matrix-product-state chain position scorer with a material base.
//
// A mode 0 item writes one weight word and never raises busy. A mode 1 item (a square)
// runs a sequencer around one shared 17x17 multiply-accumulate unit: for each column of
// the matrix product, VEC_DIM multiply-adds behind the registered store read, then
// rounding and the norm; a square root over 20 steps; a restoring division per element;
// and a closing state. The division is skipped when the product is all zero. The first
// square of a board first loads the side vector; the scoring square runs a dot product
// in place of the matrix product. busy is high throughout; o_valid pulses one cycle with
// the score, in the same cycle that busy falls, and cannot be stalled. The weight store
// read is registered; unwritten words read as anything.
module mps_chain_position_scorer_core #(
    parameter int unsigned VEC_DIM = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_mode,
    input  logic [17:0]        i_weight_addr,
    input  logic signed [15:0] i_weight_value,
    input  logic [3:0]         i_piece_code,
    input  logic               i_black_to_move,
    input  logic               i_last_square,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [15:0] o_score
);
    import mps_pkg::*;

    localparam int unsigned DW        = (VEC_DIM > 1) ? $clog2(VEC_DIM) : 1;
    localparam longint      BulkBase  = 2 * VEC_DIM;
    localparam longint      RightBase = BulkBase + longint'(BulkSites) * PieceCodes
                                        * VEC_DIM * VEC_DIM;
    localparam longint      FullDepth = RightBase + longint'(PieceCodes) * VEC_DIM;
    localparam longint      Depth     = (FullDepth < 262144) ? FullDepth : 262144;
    localparam int unsigned AccW      = 50;

    logic signed [15:0] mem [Depth];
    logic signed [15:0] r_rdata;
    logic [AddrW-1:0]   rd_addr;

    t_state r_state, n_state;
    logic [15:0]        r_scale;
    logic signed [15:0] r_vec [VEC_DIM];
    logic signed [15:0] r_prod [VEC_DIM];
    logic [DW-1:0]      r_j, n_j;
    logic [DW:0]        r_k, n_k;
    logic [6:0]         r_site;
    logic [13:0]        r_white, r_black;
    logic               r_side;
    logic [3:0]         r_piece;
    logic [39:0]        r_norm;
    logic [39:0]        r_rem;
    logic [39:0]        r_root;
    logic [5:0]         r_step;
    logic [31:0]        r_num;
    logic [31:0]        r_quo;
    logic [21:0]        r_drem;
    logic               r_valid;
    logic signed [15:0] r_score;
    t_mac_op            mac_op;
    logic signed [16:0] mac_a, mac_b;
    logic signed [AccW-1:0] acc;
    logic [3:0]         piece_in;

    assign piece_in = (i_piece_code >= 4'(PieceCodes)) ? 4'd0 : i_piece_code;

    always_ff @(posedge i_clk) begin
        if (!busy && start && !i_mode && ({14'd0, i_weight_addr} < 32'(Depth)))
            mem[i_weight_addr] <= i_weight_value;
        r_rdata <= mem[rd_addr];
    end

    mps_mac #(.AccW(AccW)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (mac_op),
        .i_a     (mac_a),
        .i_b     (mac_b),
        .o_acc   (acc)
    );

    // column sum rounding and saturation
    logic [AccW-1:0]   acc_mag;
    logic [AccW-1:0]   acc_rnd;
    logic signed [AccW-1:0] p_full;
    logic signed [15:0] p_sat;
    assign acc_mag = acc[AccW-1] ? AccW'(-acc) : AccW'(acc);
    assign acc_rnd = (acc_mag + AccW'(1 << (Frac - 1))) >> Frac;
    assign p_full  = acc[AccW-1] ? -$signed(acc_rnd) : $signed(acc_rnd);
    assign p_sat   = (p_full > 32767) ? 16'sh7fff :
                     (p_full < -32768) ? -16'sh8000 : p_full[15:0];

    // square root step
    logic [39:0] sq_bit, sq_try;
    assign sq_bit = 40'd1 << {r_step[4:0] - 5'd1, 1'b0};
    assign sq_try = r_root + sq_bit;

    // division step: quotient of m*2^15+r by 2r
    logic [22:0] dv_sh;
    logic [21:0] dv_d;
    assign dv_d  = {1'b0, r_root[19:0], 1'b0};
    assign dv_sh = {r_drem, r_num[31]};

    // scoring
    logic signed [AccW+17:0] resid;
    logic signed [AccW+17:0] lim_r, lim_t, total, tmag;
    logic signed [15:0] material;
    assign resid    = $signed(acc) * $signed({1'b0, r_scale});
    assign lim_r    = (AccW+18)'(400) <<< ScoreShift;
    assign lim_t    = (AccW+18)'(30000) <<< ScoreShift;
    assign material = r_side ? 16'($signed({2'b0, r_black}) - $signed({2'b0, r_white}))
                             : 16'($signed({2'b0, r_white}) - $signed({2'b0, r_black}));
    logic signed [AccW+17:0] rc;
    always_comb begin
        rc = (resid > lim_r) ? lim_r : (resid < -lim_r) ? -lim_r : resid;
        total = ((AccW+18)'(material) <<< ScoreShift) + rc;
        if (total > lim_t) total = lim_t;
        if (total < -lim_t) total = -lim_t;
        tmag = total[AccW+17] ? -total : total;
        tmag = tmag >>> ScoreShift;
    end

    logic [63:0] bulk_addr;
    always_comb begin
        bulk_addr = 64'(BulkBase) + ((64'(r_site) * PieceCodes + 64'(r_piece)) * VEC_DIM
                    + 64'(r_k[DW-1:0])) * VEC_DIM + 64'(r_j);
        rd_addr = '0;
        case (r_state)
            t_load_s: rd_addr = AddrW'(64'(r_side) * VEC_DIM + 64'(r_k[DW-1:0]));
            t_mac_s:  rd_addr = AddrW'(bulk_addr);
            t_dot_s:  rd_addr = AddrW'(64'(RightBase) + 64'(r_piece) * VEC_DIM
                                       + 64'(r_k[DW-1:0]));
            default:  rd_addr = '0;
        endcase
    end

    logic k_lag;
    logic [DW-1:0] k_prev;
    assign k_lag  = (r_k != '0);
    assign k_prev = r_k[DW-1:0] - 1'b1;

    logic first_sq, is_last;
    assign first_sq = (r_site == 7'd0);
    assign is_last  = i_last_square || (r_site >= 7'(BulkSites));

    always_comb begin
        n_state = r_state;
        n_j = r_j;
        n_k = r_k;
        mac_op = t_op_none;
        mac_a = '0;
        mac_b = '0;
        case (r_state)
            t_idle_s: begin
                n_k = '0;
                n_j = '0;
                if (start && i_mode)
                    n_state = first_sq ? t_load_s : (is_last ? t_dot_s : t_mac_s);
            end
            t_load_s: begin
                n_k = r_k + 1'b1;
                if (r_k == (DW+1)'(VEC_DIM)) begin
                    n_k = '0;
                    n_state = r_step[0] ? t_dot_s : t_mac_s;
                end
            end
            t_mac_s: begin
                if (k_lag) begin
                    mac_op = t_op_mac;
                    mac_a = 17'(r_vec[k_prev]);
                    mac_b = 17'(r_rdata);
                end
                n_k = r_k + 1'b1;
                if (r_k == (DW+1)'(VEC_DIM)) begin
                    n_k = '0;
                    n_state = t_col_s;
                end
            end
            t_col_s: begin
                mac_op = t_op_clear;
                n_j = r_j + 1'b1;
                n_state = t_mac_s;
                if (r_j == DW'(VEC_DIM - 1)) begin
                    n_j = '0;
                    n_state = t_sqrt_s;
                end
            end
            t_sqrt_s: begin
                if (r_step == 6'd0) begin
                    n_state = t_div_s;
                    if (r_norm == '0) n_state = t_done_s;
                end
            end
            t_div_s: begin
                if (r_step == 6'd0) begin
                    n_j = r_j + 1'b1;
                    if (r_j == DW'(VEC_DIM - 1)) begin
                        n_j = '0;
                        n_state = t_done_s;
                    end
                end
            end
            t_dot_s: begin
                if (k_lag) begin
                    mac_op = t_op_mac;
                    mac_a = 17'(r_vec[k_prev]);
                    mac_b = 17'(r_rdata);
                end
                n_k = r_k + 1'b1;
                if (r_k == (DW+1)'(VEC_DIM)) begin
                    n_k = '0;
                    n_state = t_score_s;
                end
            end
            t_score_s: begin
                mac_op = t_op_clear;
                n_state = t_idle_s;
            end
            t_done_s: n_state = t_idle_s;
            default: n_state = t_idle_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle_s;
            r_scale <= 16'd25600;
            r_site  <= '0;
            r_white <= '0;
            r_black <= '0;
            r_side  <= 1'b0;
            r_j     <= '0;
            r_k     <= '0;
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_j <= n_j;
            r_k <= n_k;
            r_valid <= 1'b0;
            if (i_cfg_we) r_scale <= i_cfg_data;
            case (r_state)
                t_idle_s: begin
                    if (start && i_mode) begin
                        r_piece <= piece_in;
                        if (first_sq) begin
                            r_side <= i_black_to_move;
                            r_white <= '0;
                            r_black <= '0;
                            if (piece_in >= 4'd1 && piece_in <= 4'd6)
                                r_white <= add_mat(14'd0, piece_value(piece_in));
                            else if (piece_in >= 4'd7)
                                r_black <= add_mat(14'd0, piece_value(piece_in));
                        end else begin
                            if (piece_in >= 4'd1 && piece_in <= 4'd6)
                                r_white <= add_mat(r_white, piece_value(piece_in));
                            else if (piece_in >= 4'd7)
                                r_black <= add_mat(r_black, piece_value(piece_in));
                        end
                        r_step  <= {5'd0, is_last};
                        r_norm  <= '0;
                    end
                end
                t_load_s: begin
                    if (k_lag) r_vec[k_prev] <= r_rdata;
                end
                t_col_s: begin
                    r_prod[r_j] <= p_sat;
                    r_norm <= r_norm + 40'(32'($signed(p_sat) * $signed(p_sat)));
                    if (r_j == DW'(VEC_DIM - 1)) begin
                        r_step <= 6'd20;
                        r_root <= '0;
                        r_rem  <= r_norm + 40'(32'($signed(p_sat) * $signed(p_sat)));
                    end
                end
                t_sqrt_s: begin
                    if (r_step == 6'd0) begin
                        if (r_norm == '0) begin
                            for (int i = 0; i < VEC_DIM; i++) r_vec[i] <= r_prod[i];
                            r_site <= r_site + 1'b1;
                        end else begin
                            r_step <= 6'd32;
                            r_drem <= '0;
                            r_num  <= {1'b0, (r_prod[0][15] ? 16'(-r_prod[0]) : r_prod[0]),
                                       15'd0} + {12'd0, r_root[19:0]};
                            r_quo  <= '0;
                        end
                    end else begin
                        if ({r_rem} >= sq_try) begin
                            r_rem  <= r_rem - sq_try;
                            r_root <= (r_root >> 1) + sq_bit;
                        end else begin
                            r_root <= r_root >> 1;
                        end
                        r_step <= r_step - 1'b1;
                    end
                end
                t_div_s: begin
                    if (r_step == 6'd0) begin
                        r_vec[r_j] <= r_prod[r_j][15] ? -16'(r_quo) : 16'(r_quo);
                        if (r_j == DW'(VEC_DIM - 1)) r_site <= r_site + 1'b1;
                        else begin
                            r_step <= 6'd32;
                            r_drem <= '0;
                            r_quo  <= '0;
                            r_num  <= {1'b0, (r_prod[r_j+1'b1][15] ? 16'(-r_prod[r_j+1'b1])
                                       : r_prod[r_j+1'b1]), 15'd0} + {12'd0, r_root[19:0]};
                        end
                    end else begin
                        r_num <= r_num << 1;
                        if ({1'b0, dv_sh} >= {2'b0, dv_d}) begin
                            r_drem <= 22'(dv_sh - {1'b0, dv_d});
                            r_quo  <= {r_quo[30:0], 1'b1};
                        end else begin
                            r_drem <= dv_sh[21:0];
                            r_quo  <= {r_quo[30:0], 1'b0};
                        end
                        r_step <= r_step - 1'b1;
                    end
                end
                t_score_s: begin
                    r_valid <= 1'b1;
                    r_score <= total[AccW+17] ? -16'(tmag) : 16'(tmag);
                    r_site  <= '0;
                end
                default: ;
            endcase
        end
    end

    assign busy    = (r_state != t_idle_s);
    assign o_valid = r_valid;
    assign o_score = r_score;

    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_valid |-> !busy)
        else $error("score strobe while busy");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_score <= 16'sd30000 && o_score >= -16'sd30000))
        else $error("score out of range");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && !i_mode) |=> !busy)
        else $error("weight write made block busy");
endmodule
